@@ rtl/wstd_pkg.sv @@
// shared types and codes for the work-stealing task deque
`default_nettype none

package wstd_pkg;

	// fixed field widths of the channels
	localparam int FUNC_W     = 3;
	localparam int TASK_IN_W  = 32;
	localparam int TASK_OUT_W = 32;
	localparam int STATUS_W   = 2;
	localparam int OCC_W      = 7;

	// command queue between front and back
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = 1;
	localparam int CQ_CNT_W = 2;

	// function codes on the input channel
	localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_STEAL      = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	// decoded operation
	typedef enum logic [2:0] {
		OP_PUSH_FRONT,
		OP_POP_FRONT,
		OP_PUSH_BACK,
		OP_POP_BACK,
		OP_STEAL,
		OP_NOP
	} op_t;

	// execution sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_TAKE
	} state_t;

	// input transaction
	typedef struct packed {
		logic [FUNC_W-1:0]    func;
		logic [TASK_IN_W-1:0] task_req;
	} item_t;

	// output transaction
	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [TASK_OUT_W-1:0] task_out;
		logic                  last;
		logic [OCC_W-1:0]      occupancy;
	} result_t;

	// classified command held in the queue
	typedef struct packed {
		op_t                  op;
		logic [TASK_IN_W-1:0] task_req;
	} cmd_t;

	// head of the command queue as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cq_head_t;

endpackage

`default_nettype wire

@@ rtl/wstd_front.sv @@
// front end: accepts input transactions, decodes them and queues commands
`default_nettype none

module wstd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	output logic                  cmd_stall,
	input  wire wstd_pkg::item_t  cmd,
	output wstd_pkg::cq_head_t    cq,
	input  wire logic             cq_pop
);

	wstd_pkg::cmd_t                 entry_q [wstd_pkg::CQ_DEPTH];
	logic [wstd_pkg::CQ_PTR_W-1:0]  wr_ptr_q;
	logic [wstd_pkg::CQ_PTR_W-1:0]  rd_ptr_q;
	logic [wstd_pkg::CQ_CNT_W-1:0]  count_q;
	logic                           push;
	wstd_pkg::op_t                  op_dec;

	// decode the function code
	always_comb begin
		case (cmd.func)
			wstd_pkg::FUNC_PUSH_FRONT: op_dec = wstd_pkg::OP_PUSH_FRONT;
			wstd_pkg::FUNC_POP_FRONT:  op_dec = wstd_pkg::OP_POP_FRONT;
			wstd_pkg::FUNC_PUSH_BACK:  op_dec = wstd_pkg::OP_PUSH_BACK;
			wstd_pkg::FUNC_POP_BACK:   op_dec = wstd_pkg::OP_POP_BACK;
			wstd_pkg::FUNC_STEAL:      op_dec = wstd_pkg::OP_STEAL;
			default:                   op_dec = wstd_pkg::OP_NOP;
		endcase
	end

	// stall only on a full queue
	assign cmd_stall = (count_q == wstd_pkg::CQ_CNT_W'(wstd_pkg::CQ_DEPTH));
	assign push      = cmd_valid && !cmd_stall;

	// queue head towards the back end
	assign cq.valid = (count_q != '0);
	assign cq.cmd   = entry_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q].op       <= op_dec;
			entry_q[wr_ptr_q].task_req <= cmd.task_req;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cq_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, cq_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/wstd_exec.sv @@
// back end: ring storage, slot flags, end indexes and the operation sequencer
`default_nettype none

module wstd_exec #(
	parameter int CAPACITY  = 64,
	parameter int TASK_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire wstd_pkg::cq_head_t cq,
	output logic                    cq_pop,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output wstd_pkg::result_t       res
);

	localparam int RING = 2 * CAPACITY;
	localparam int IW   = $clog2(RING);
	localparam int SW   = $clog2(CAPACITY);

	// ring index helpers, indexes run modulo twice the capacity
	function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] a);
		ring_inc = (a == IW'(RING - 1)) ? '0 : a + IW'(1);
	endfunction

	function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] a);
		ring_dec = (a == '0) ? IW'(RING - 1) : a - IW'(1);
	endfunction

	function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] a, input logic [IW-1:0] d);
		logic [IW:0] sum;
		sum = {1'b0, a} + {1'b0, d};
		if (sum >= (IW + 1)'(RING)) begin
			sum = sum - (IW + 1)'(RING);
		end
		ring_add = sum[IW-1:0];
	endfunction

	function automatic logic [IW-1:0] ring_sub(input logic [IW-1:0] a, input logic [IW-1:0] b);
		ring_sub = (a >= b) ? a - b : a + IW'(RING) - b;
	endfunction

	function automatic logic [SW-1:0] slot_of(input logic [IW-1:0] a);
		slot_of = (a >= IW'(CAPACITY)) ? SW'(a - IW'(CAPACITY)) : SW'(a);
	endfunction

	function automatic logic [IW-1:0] clamp_occ(input logic [IW-1:0] size);
		clamp_occ = (size > IW'(CAPACITY)) ? IW'(CAPACITY) : size;
	endfunction

	// state
	wstd_pkg::state_t        state_q, state_d;
	logic [IW-1:0]           front_q, front_d;
	logic [IW-1:0]           back_q, back_d;
	logic [IW-1:0]           base_q, base_d;
	logic [SW-1:0]           off_q, off_d;
	logic                    taken_q, taken_d;
	logic                    last_q, last_d;
	logic [CAPACITY-1:0]     full_q;
	logic [TASK_BITS-1:0]    slot_mem [CAPACITY];
	logic [TASK_BITS-1:0]    rdata_q;
	wstd_pkg::result_t       res_q, res_d;
	logic                    res_valid_q;

	// datapath controls
	logic                    mem_we, mem_re;
	logic [SW-1:0]           mem_addr;
	logic                    full_set, full_clr;
	logic                    res_load;
	logic [1:0]              res_status;
	logic [TASK_BITS-1:0]    res_task;
	logic                    res_last;

	// shared decisions
	logic                    out_free, dispatch;
	logic [SW-1:0]           s_front, s_front_m1, s_back, s_back_m1, s_scan;
	logic [IW-1:0]           scan_pos, size_now;
	logic [SW-1:0]           steal_off;
	logic [TASK_BITS+wstd_pkg::TASK_IN_W-1:0]  task_in_ext;
	logic [TASK_BITS-1:0]    head_task;
	logic                    push_front_ok, pop_front_ok, push_back_ok, pop_back_ok;
	logic                    scan_take;
	logic [TASK_BITS+wstd_pkg::TASK_OUT_W-1:0] task_out_ext;
	logic [IW-1:0]           occ_next;
	logic [IW+wstd_pkg::OCC_W-1:0]             occ_ext;

	// slot addresses, occupancy and outcome of each operation
	always_comb begin
		out_free      = !res_valid_q || !res_stall;
		dispatch      = cq.valid && out_free;
		s_front       = slot_of(front_q);
		s_front_m1    = slot_of(ring_dec(front_q));
		s_back        = slot_of(back_q);
		s_back_m1     = slot_of(ring_dec(back_q));
		scan_pos      = ring_add(base_q, IW'(off_q));
		s_scan        = slot_of(scan_pos);
		size_now      = clamp_occ(ring_sub(front_q, back_q));
		steal_off     = SW'((size_now - IW'(1)) >> 1);
		task_in_ext   = {{TASK_BITS{1'b0}}, cq.cmd.task_req};
		head_task     = task_in_ext[TASK_BITS-1:0];
		push_front_ok = !full_q[s_front];
		pop_front_ok  = full_q[s_front_m1];
		push_back_ok  = !full_q[s_back_m1];
		pop_back_ok   = (size_now != '0) && full_q[s_back];
		scan_take     = taken_q || full_q[s_scan];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			wstd_pkg::ST_IDLE: begin
				if (dispatch) begin
					case (cq.cmd.op)
						wstd_pkg::OP_POP_FRONT: begin
							if (pop_front_ok) state_d = wstd_pkg::ST_READ;
						end
						wstd_pkg::OP_POP_BACK: begin
							if (pop_back_ok) state_d = wstd_pkg::ST_READ;
						end
						wstd_pkg::OP_STEAL: begin
							if (size_now != '0) state_d = wstd_pkg::ST_SCAN;
						end
						default: state_d = wstd_pkg::ST_IDLE;
					endcase
				end
			end
			wstd_pkg::ST_READ: begin
				if (out_free) state_d = wstd_pkg::ST_IDLE;
			end
			wstd_pkg::ST_SCAN: begin
				if (scan_take) begin
					state_d = wstd_pkg::ST_TAKE;
				end else if (off_q == '0 && out_free) begin
					state_d = wstd_pkg::ST_IDLE;
				end
			end
			wstd_pkg::ST_TAKE: begin
				if (out_free) begin
					state_d = last_q ? wstd_pkg::ST_IDLE : wstd_pkg::ST_SCAN;
				end
			end
			default: state_d = wstd_pkg::ST_IDLE;
		endcase
	end

	// datapath controls per state
	always_comb begin
		cq_pop     = 1'b0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_addr   = '0;
		full_set   = 1'b0;
		full_clr   = 1'b0;
		front_d    = front_q;
		back_d     = back_q;
		base_d     = base_q;
		off_d      = off_q;
		taken_d    = taken_q;
		last_d     = last_q;
		res_load   = 1'b0;
		res_status = wstd_pkg::STATUS_DONE;
		res_task   = '0;
		res_last   = 1'b1;
		case (state_q)
			wstd_pkg::ST_IDLE: begin
				if (dispatch) begin
					cq_pop = 1'b1;
					case (cq.cmd.op)
						wstd_pkg::OP_PUSH_FRONT: begin
							res_load = 1'b1;
							if (push_front_ok) begin
								mem_we   = 1'b1;
								mem_addr = s_front;
								full_set = 1'b1;
								front_d  = ring_inc(front_q);
							end else begin
								res_status = wstd_pkg::STATUS_FULL;
								res_task   = head_task;
							end
						end
						wstd_pkg::OP_POP_FRONT: begin
							if (pop_front_ok) begin
								mem_re   = 1'b1;
								mem_addr = s_front_m1;
								full_clr = 1'b1;
								front_d  = ring_dec(front_q);
							end else begin
								res_load   = 1'b1;
								res_status = wstd_pkg::STATUS_EMPTY;
							end
						end
						wstd_pkg::OP_PUSH_BACK: begin
							res_load = 1'b1;
							if (push_back_ok) begin
								mem_we   = 1'b1;
								mem_addr = s_back_m1;
								full_set = 1'b1;
								back_d   = ring_dec(back_q);
							end else begin
								res_status = wstd_pkg::STATUS_FULL;
								res_task   = head_task;
							end
						end
						wstd_pkg::OP_POP_BACK: begin
							if (pop_back_ok) begin
								mem_re   = 1'b1;
								mem_addr = s_back;
								full_clr = 1'b1;
								back_d   = ring_inc(back_q);
							end else begin
								res_load   = 1'b1;
								res_status = wstd_pkg::STATUS_EMPTY;
							end
						end
						wstd_pkg::OP_STEAL: begin
							if (size_now != '0) begin
								base_d  = back_q;
								off_d   = steal_off;
								taken_d = 1'b0;
							end else begin
								res_load   = 1'b1;
								res_status = wstd_pkg::STATUS_EMPTY;
							end
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			wstd_pkg::ST_READ: begin
				if (out_free) begin
					res_load = 1'b1;
					res_task = rdata_q;
				end
			end
			wstd_pkg::ST_SCAN: begin
				// walk from the middle toward the back end
				if (scan_take) begin
					mem_re   = 1'b1;
					mem_addr = s_scan;
					full_clr = 1'b1;
					taken_d  = 1'b1;
					last_d   = (off_q == '0);
					if (!taken_q) begin
						back_d = ring_inc(scan_pos);
					end
				end else if (off_q != '0) begin
					off_d = off_q - SW'(1);
				end else if (out_free) begin
					res_load   = 1'b1;
					res_status = wstd_pkg::STATUS_EMPTY;
				end
			end
			wstd_pkg::ST_TAKE: begin
				if (out_free) begin
					res_load = 1'b1;
					res_task = rdata_q;
					res_last = last_q;
					if (!last_q) begin
						off_d = off_q - SW'(1);
					end
				end
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	// result assembly, occupancy after the update
	always_comb begin
		task_out_ext     = {{wstd_pkg::TASK_OUT_W{1'b0}}, res_task};
		occ_next         = clamp_occ(ring_sub(front_d, back_d));
		occ_ext          = {{wstd_pkg::OCC_W{1'b0}}, occ_next};
		res_d.status     = res_status;
		res_d.task_out   = task_out_ext[wstd_pkg::TASK_OUT_W-1:0];
		res_d.last       = res_last;
		res_d.occupancy  = occ_ext[wstd_pkg::OCC_W-1:0];
	end

	// task storage with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_addr] <= head_task;
		end
		if (mem_re) begin
			rdata_q <= slot_mem[mem_addr];
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wstd_pkg::ST_IDLE;
			front_q     <= '0;
			back_q      <= '0;
			base_q      <= '0;
			off_q       <= '0;
			taken_q     <= 1'b0;
			last_q      <= 1'b0;
			full_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			back_q  <= back_d;
			base_q  <= base_d;
			off_q   <= off_d;
			taken_q <= taken_d;
			last_q  <= last_d;
			if (full_set) begin
				full_q[mem_addr] <= 1'b1;
			end
			if (full_clr) begin
				full_q[mem_addr] <= 1'b0;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// commands leave the queue only when the sequencer is free
	a_pop_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop |-> state_q == wstd_pkg::ST_IDLE)
		else $error("command taken while sequencer busy");

	// a memory read is always followed by a state that uses its data
	a_read_used: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> (state_q == wstd_pkg::ST_READ || state_q == wstd_pkg::ST_TAKE))
		else $error("read data not consumed");

	// only successful steal results may be non-final
	a_nonlast_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.last |-> res_q.status == wstd_pkg::STATUS_DONE)
		else $error("non-final result with error status");

	// the front index stays inside the ring
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		front_q < IW'(RING - 1) || front_q == IW'(RING - 1))
		else $error("front index out of range");

	// memory access is never a read and write at once
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("memory read and write in one cycle");

endmodule

`default_nettype wire

@@ rtl/work_stealing_task_deque.sv @@
// top level of the work-stealing task deque
//
// channel | valid     | stall     | payload            | transaction
// --------+-----------+-----------+--------------------+------------------------------
// command | cmd_valid | cmd_stall | cmd  (item_t)      | one deque operation
// result  | res_valid | res_stall | res  (result_t)    | one result, last marks the end
//
// A command waits in the two-entry command queue until the sequencer is free, then the
// sequencer dispatches it: pushes, failed pops or steals, and unknown codes give their
// result the next cycle; successful pops first pass the registered slot memory read.
// Steal-half skips empty slots from the middle toward the back, then reads each task and sends its result.
// Reset clears the slot flags and indexes at once; the slot memory needs no clearing.
// A stalled result holds the sequencer while the queue still takes up to two commands.
`default_nettype none

module work_stealing_task_deque #(
	parameter int CAPACITY  = 64,
	parameter int TASK_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire wstd_pkg::item_t   cmd,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output wstd_pkg::result_t      res
);

	wstd_pkg::cq_head_t cq;
	logic               cq_pop;

	// accept and classify
	wstd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.cq        (cq),
		.cq_pop    (cq_pop)
	);

	// execute against the ring
	wstd_exec #(
		.CAPACITY  (CAPACITY),
		.TASK_BITS (TASK_BITS)
	) u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cq        (cq),
		.cq_pop    (cq_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

`default_nettype wire
